[hw/rtl/swd_pkg.sv]
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types and constants for the scaled Wiener deconvolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package swd_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int RES_W           = 32;
  localparam int GAIN_W          = 16;
  localparam int ENERGY_W        = 44;
  localparam int PH_W            = 32;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK = 2'd1;

  localparam logic [CFG_W-1:0]    SHRINK_RESET = 16'd32768;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX   = {ENERGY_W{1'b1}};

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_APPLY   = 1'b1;

  // apply item handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sr;
    logic signed [SAMPLE_W-1:0] si;
    logic signed [SAMPLE_W-1:0] hr;
    logic signed [SAMPLE_W-1:0] hi;
    logic [PH_W-1:0]            ph;
    logic [ENERGY_W-1:0]        energy;
  } swd_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } swd_qstat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_GDIV,
    B_SCALE,
    B_QDIV,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

[hw/rtl/scaled_wiener_deconvolution.sv]
// ----------------------------------------------------------------------------
// scaled_wiener_deconvolution
// Two-pass per-bin scaled Wiener deconvolution: measure items build the
// impulse energy, apply items give the gained, deconvolved bin.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   kind, restart, signal, impulse
//  out_     output     out_valid/out_stall result re/im, gain, zero_impulse
//  cfg_     input      cfg_we              cfg_index, cfg_wdata
//
//  Every item passes through the front stage register; measure items end there.
//  Apply items then run in the back (1 pop, 15 multiply steps on one
//  33x33 multiplier, 16 gain divide steps, 2 scale, 32 quotient, 1 load);
//  no gain divide when the gain saturates or is zero; zero impulse: pop, load.
//  A two-entry queue lets measure items flow while the back is busy.
//  Synchronous reset, no clearing pass; output register holds under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_wiener_deconvolution #(
  parameter int SAMPLE_BITS = swd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_kind,
  input  wire logic                                in_restart,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_signal_re,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_signal_im,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_impulse_re,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_impulse_im,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [swd_pkg::RES_W-1:0]         out_result_re,
  output logic signed [swd_pkg::RES_W-1:0]         out_result_im,
  output logic [swd_pkg::GAIN_W-1:0]               out_gain,
  output logic                                     out_zero_impulse,
  input  wire logic                                cfg_we,
  input  wire logic [swd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [swd_pkg::CFG_W-1:0]           cfg_wdata
);
  import swd_pkg::*;

  logic [CFG_W-1:0] noise_dev_r, shrink_r;
  swd_item_t  push_item, head;
  swd_qstat_t qstat;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_dev_r <= '0;
      shrink_r    <= SHRINK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOISE:  noise_dev_r <= cfg_wdata;
        CFG_SHRINK: shrink_r    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  swd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_restart    (in_restart),
    .in_signal_re  (in_signal_re),
    .in_signal_im  (in_signal_im),
    .in_impulse_re (in_impulse_re),
    .in_impulse_im (in_impulse_im),
    .qstat         (qstat),
    .push          (push),
    .push_item     (push_item)
  );

  swd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  swd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .qstat            (qstat),
    .pop              (pop),
    .noise_dev        (noise_dev_r),
    .shrink           (shrink_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_re    (out_result_re),
    .out_result_im    (out_result_im),
    .out_gain         (out_gain),
    .out_zero_impulse (out_zero_impulse)
  );

endmodule

`default_nettype wire

[hw/rtl/swd_front.sv]
// ----------------------------------------------------------------------------
// swd_front
// Accepts items, squares the impulse bin, runs the energy accumulator for
// measure items and queues apply items with the current energy.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_front #(
  parameter int SAMPLE_BITS = swd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_kind,
  input  wire logic                            in_restart,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_signal_re,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_signal_im,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_impulse_re,
  input  wire logic signed [swd_pkg::SAMPLE_W-1:0] in_impulse_im,
  input  wire swd_pkg::swd_qstat_t             qstat,
  output logic                                 push,
  output swd_pkg::swd_item_t                   push_item
);
  import swd_pkg::*;

  localparam int SB = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  function automatic logic signed [SAMPLE_W-1:0] sext(input logic [SAMPLE_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    for (int i = 0; i < SAMPLE_W; i++) begin
      r[i] = (i < SB) ? v[i] : v[SB-1];
    end
    return $signed(r);
  endfunction

  logic s_v_r, s_v_nxt;
  logic s_kind_r, s_restart_r;
  logic signed [SAMPLE_W-1:0] s_sr_r, s_si_r, s_hr_r, s_hi_r;
  logic [PH_W-1:0] sqa_r, sqb_r;
  logic [ENERGY_W-1:0] energy_r, energy_nxt;

  logic signed [SAMPLE_W-1:0] hr_x, hi_x;
  logic signed [2*SAMPLE_W-1:0] sqa, sqb;
  logic [PH_W-1:0] ph;
  logic [ENERGY_W-1:0] e_base;
  logic [ENERGY_W:0] e_sum;
  logic s_go, accept;

  assign hr_x = sext(in_impulse_re);
  assign hi_x = sext(in_impulse_im);
  assign sqa  = hr_x * hr_x;
  assign sqb  = hi_x * hi_x;

  assign ph       = sqa_r + sqb_r;
  assign s_go     = s_v_r && (s_kind_r == KIND_MEASURE || !qstat.full);
  assign in_stall = s_v_r && !s_go;
  assign accept   = in_valid && !in_stall;
  assign push     = s_v_r && (s_kind_r == KIND_APPLY) && !qstat.full;

  assign push_item.sr     = s_sr_r;
  assign push_item.si     = s_si_r;
  assign push_item.hr     = s_hr_r;
  assign push_item.hi     = s_hi_r;
  assign push_item.ph     = ph;
  assign push_item.energy = energy_r;

  always_comb begin
    s_v_nxt = s_v_r;
    if (accept) begin
      s_v_nxt = 1'b1;
    end else if (s_go) begin
      s_v_nxt = 1'b0;
    end
  end

  // saturating accumulate; restart clears before adding
  always_comb begin
    e_base     = s_restart_r ? '0 : energy_r;
    e_sum      = {1'b0, e_base} + {{(ENERGY_W+1-PH_W){1'b0}}, ph};
    energy_nxt = energy_r;
    if (s_go && s_kind_r == KIND_MEASURE) begin
      energy_nxt = e_sum[ENERGY_W] ? ENERGY_MAX : e_sum[ENERGY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r    <= 1'b0;
      energy_r <= '0;
    end else begin
      s_v_r    <= s_v_nxt;
      energy_r <= energy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_kind_r    <= in_kind;
      s_restart_r <= in_restart;
      s_sr_r      <= sext(in_signal_re);
      s_si_r      <= sext(in_signal_im);
      s_hr_r      <= hr_x;
      s_hi_r      <= hi_x;
      sqa_r       <= $unsigned(sqa);
      sqb_r       <= $unsigned(sqb);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/swd_queue.sv]
// ----------------------------------------------------------------------------
// swd_queue
// Two-entry item queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire swd_pkg::swd_item_t push_item,
  input  wire logic               pop,
  output swd_pkg::swd_item_t      head,
  output swd_pkg::swd_qstat_t     qstat
);
  import swd_pkg::*;

  swd_item_t  ent_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head        = ent_r[rp_r];
  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/swd_back.sv]
// ----------------------------------------------------------------------------
// swd_back
// Sequencer that computes gain and deconvolved bin for one apply item with a
// shared 33x33 multiplier and bit-serial dividers, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swd_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire swd_pkg::swd_item_t        head,
  input  wire swd_pkg::swd_qstat_t       qstat,
  output logic                           pop,
  input  wire logic [swd_pkg::CFG_W-1:0] noise_dev,
  input  wire logic [swd_pkg::CFG_W-1:0] shrink,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [swd_pkg::RES_W-1:0] out_result_re,
  output logic signed [swd_pkg::RES_W-1:0] out_result_im,
  output logic [swd_pkg::GAIN_W-1:0]     out_gain,
  output logic                           out_zero_impulse
);
  import swd_pkg::*;

  localparam logic [4:0] MUL_LAST  = 5'd14;
  localparam logic [4:0] GDIV_LAST = 5'd15;
  localparam logic [4:0] QDIV_LAST = 5'd31;

  back_state_t state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;

  swd_item_t          it_r;
  logic               zf_r;
  logic signed [32:0] tmp_r, nre_r, nim_r;
  logic [31:0]        ps_r;
  logic [63:0]        pp_r;
  logic [47:0]        k_r;
  logic [95:0]        acc_r, tot_r;
  logic [79:0]        num_r;
  logic [96:0]        rem_r;
  logic [15:0]        g_r;
  logic [31:0]        dre_r, dim_r, qre_r, qim_r;
  logic [32:0]        rre_r, rim_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic [96:0]        g_r2;
  logic [32:0]        re_r2, im_r2;
  logic signed [32:0] are, aim;
  logic               out_load, gdiv_skip;
  logic [RES_W-1:0]   res_re, res_im;

  function automatic logic signed [32:0] sx(input logic signed [SAMPLE_W-1:0] v);
    return $signed({{(33-SAMPLE_W){v[SAMPLE_W-1]}}, v});
  endfunction

  function automatic logic [RES_W-1:0] sat(input logic neg, input logic [31:0] q);
    logic [31:0] m;
    if (neg) begin
      m = (q > 32'h8000_0000) ? 32'h8000_0000 : q;
      return 32'd0 - m;
    end
    return (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
  endfunction

  assign are = nre_r[32] ? -nre_r : nre_r;
  assign aim = nim_r[32] ? -nim_r : nim_r;

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_r == B_MUL) begin
      case (step_r)
        5'd0:  begin ma = sx(it_r.sr); mb = sx(it_r.sr); end
        5'd1:  begin ma = sx(it_r.si); mb = sx(it_r.si); end
        5'd2:  begin ma = sx(it_r.sr); mb = sx(it_r.hr); end
        5'd3:  begin ma = sx(it_r.si); mb = sx(it_r.hi); end
        5'd4:  begin ma = sx(it_r.si); mb = sx(it_r.hr); end
        5'd5:  begin ma = sx(it_r.sr); mb = sx(it_r.hi); end
        5'd6:  begin ma = $signed({1'b0, it_r.ph}); mb = $signed({1'b0, ps_r}); end
        5'd7:  begin ma = $signed({17'd0, shrink}); mb = $signed({17'd0, noise_dev}); end
        5'd8:  begin ma = $signed({1'b0, k_r[31:0]}); mb = $signed({17'd0, noise_dev}); end
        5'd9:  begin ma = $signed({1'b0, k_r[31:0]}); mb = $signed({1'b0, it_r.energy[31:0]}); end
        5'd10: begin ma = $signed({17'd0, k_r[47:32]}); mb = $signed({1'b0, it_r.energy[31:0]}); end
        5'd11: begin ma = $signed({1'b0, k_r[31:0]}); mb = $signed({21'd0, it_r.energy[43:32]}); end
        5'd12: begin ma = $signed({17'd0, k_r[47:32]}); mb = $signed({21'd0, it_r.energy[43:32]}); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else if (state_r == B_SCALE) begin
      ma = (step_r == 5'd0) ? are : aim;
      mb = $signed({17'd0, g_r});
    end
  end

  assign prod = ma * mb;

  assign g_r2  = {rem_r[95:0], 1'b0};
  assign re_r2 = {rre_r[31:0], dre_r[31]};
  assign im_r2 = {rim_r[31:0], dim_r[31]};
  assign gdiv_skip = (tot_r == '0) || ({16'd0, num_r} >= tot_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      B_IDLE: begin
        if (!qstat.empty) begin
          state_nxt = (head.ph == '0) ? B_DONE : B_MUL;
          step_nxt  = '0;
        end
      end
      B_MUL: begin
        step_nxt = step_r + 5'd1;
        if (step_r == MUL_LAST) begin
          state_nxt = gdiv_skip ? B_SCALE : B_GDIV;
          step_nxt  = '0;
        end
      end
      B_GDIV: begin
        step_nxt = step_r + 5'd1;
        if (step_r == GDIV_LAST) begin
          state_nxt = B_SCALE;
          step_nxt  = '0;
        end
      end
      B_SCALE: begin
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd1) begin
          state_nxt = B_QDIV;
          step_nxt  = '0;
        end
      end
      B_QDIV: begin
        step_nxt = step_r + 5'd1;
        if (step_r == QDIV_LAST) begin
          state_nxt = B_DONE;
          step_nxt  = '0;
        end
      end
      B_DONE: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      B_IDLE:  pop      = !qstat.empty;
      B_DONE:  out_load = !out_valid_r || !out_stall;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      it_r <= head;
      zf_r <= (head.ph == '0);
    end
    if (state_r == B_MUL) begin
      case (step_r)
        5'd0:  tmp_r <= prod[32:0];
        5'd1:  ps_r  <= tmp_r[31:0] + prod[31:0];
        5'd2:  tmp_r <= prod[32:0];
        5'd3:  nre_r <= tmp_r + prod[32:0];
        5'd4:  tmp_r <= prod[32:0];
        5'd5:  nim_r <= tmp_r - prod[32:0];
        5'd6:  pp_r  <= prod[63:0];
        5'd7:  k_r   <= prod[47:0];
        5'd8:  k_r   <= prod[47:0];
        5'd9:  acc_r <= {32'd0, prod[63:0]};
        5'd10: acc_r <= acc_r + {prod[63:0], 32'd0};
        5'd11: acc_r <= acc_r + {prod[63:0], 32'd0};
        5'd12: acc_r <= acc_r + {prod[31:0], 64'd0};
        5'd13: begin
          num_r <= {pp_r, 16'd0};
          tot_r <= {16'd0, pp_r, 16'd0} + acc_r;
        end
        default: begin
          rem_r <= {17'd0, num_r};
          // zero over zero gives 0, no noise term gives full scale
          if (tot_r == '0) begin
            g_r <= '0;
          end else if ({16'd0, num_r} >= tot_r) begin
            g_r <= 16'hFFFF;
          end else begin
            g_r <= '0;
          end
        end
      endcase
    end
    if (state_r == B_GDIV) begin
      if (g_r2 >= {1'b0, tot_r}) begin
        rem_r <= g_r2 - {1'b0, tot_r};
        g_r   <= {g_r[14:0], 1'b1};
      end else begin
        rem_r <= g_r2;
        g_r   <= {g_r[14:0], 1'b0};
      end
    end
    if (state_r == B_SCALE) begin
      // floor(floor(x/65536)/ph) equals floor(x/(ph*65536))
      if (step_r == 5'd0) begin
        dre_r <= prod[47:16];
      end else begin
        dim_r <= prod[47:16];
      end
      rre_r <= '0;
      rim_r <= '0;
    end
    if (state_r == B_QDIV) begin
      dre_r <= {dre_r[30:0], 1'b0};
      dim_r <= {dim_r[30:0], 1'b0};
      if (re_r2 >= {1'b0, it_r.ph}) begin
        rre_r <= re_r2 - {1'b0, it_r.ph};
        qre_r <= {qre_r[30:0], 1'b1};
      end else begin
        rre_r <= re_r2;
        qre_r <= {qre_r[30:0], 1'b0};
      end
      if (im_r2 >= {1'b0, it_r.ph}) begin
        rim_r <= im_r2 - {1'b0, it_r.ph};
        qim_r <= {qim_r[30:0], 1'b1};
      end else begin
        rim_r <= im_r2;
        qim_r <= {qim_r[30:0], 1'b0};
      end
    end
  end

  assign res_re = sat(nre_r[32], qre_r);
  assign res_im = sat(nim_r[32], qim_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result_re    <= zf_r ? '0 : $signed(res_re);
      out_result_im    <= zf_r ? '0 : $signed(res_im);
      out_gain         <= zf_r ? '0 : g_r;
      out_zero_impulse <= zf_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
